>>> sv/hslp_pkg.sv
// Shared types and constants for the linear-probing hash set.
package hslp_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned KEY_BYTES   = 8;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned SIZE_W      = IDX_W + 1;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned HASH_W      = 32;
  localparam int unsigned OP_W        = 2;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] SLOT_EMPTY  = 2'd0;
  localparam logic [1:0] SLOT_FILLED = 2'd1;
  localparam logic [1:0] SLOT_TOMB   = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] start;
  } req_t;

endpackage

>>> sv/hslp_fifo.sv
// Two-entry queue that carries classified requests from the front to the back.
module hslp_fifo
  import hslp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output req_t rdata_o,
  output logic empty_o
);

  req_t       mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = ~wptr_q;
    end
    if (do_pop) begin
      rptr_d = ~rptr_q;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> sv/hslp_front.sv
// Front end: accepts requests, normalizes the key, hashes it and reduces it to a start slot.
module hslp_front
  import hslp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [KEY_W-1:0]  key_bytes_i,
  input  logic              hold_i,
  input  logic [SIZE_W-1:0] size_i,
  output logic              busy_o,
  output logic              q_push_o,
  output req_t              q_data_o,
  input  logic              q_full_i
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_HASH = 2'd1;
  localparam logic [1:0] F_MOD  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]          st_q, st_d;
  logic [OP_W-1:0]     op_q;
  logic [KEY_W-1:0]    norm_q, norm_d;
  logic [KEY_W-1:0]    sh_q, sh_d;
  logic [HASH_W-1:0]   h_q, h_d;
  logic [SIZE_W-1:0]   rem_q, rem_d;
  logic [2:0]          bcnt_q, bcnt_d;
  logic [4:0]          mcnt_q, mcnt_d;
  logic [7:0]          cur_byte;
  logic [SIZE_W:0]     trial;
  logic                accept;

  assign busy_o   = (st_q != F_IDLE) || hold_i;
  assign accept   = push_i && !busy_o;
  assign cur_byte = sh_q[KEY_W-1 -: 8];
  assign trial    = {rem_q, h_q[HASH_W-1]};
  assign q_push_o = (st_q == F_PUSH);
  assign q_data_o = '{op: op_q, key: norm_q, start: rem_q[IDX_W-1:0]};

  always_comb begin
    logic alive;
    alive  = 1'b1;
    norm_d = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (key_bytes_i[KEY_W-1-8*b -: 8] == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        norm_d[KEY_W-1-8*b -: 8] = key_bytes_i[KEY_W-1-8*b -: 8];
      end
    end
  end

  always_comb begin
    st_d   = st_q;
    sh_d   = sh_q;
    h_d    = h_q;
    rem_d  = rem_q;
    bcnt_d = bcnt_q;
    mcnt_d = mcnt_q;
    unique case (st_q)
      F_IDLE: begin
        if (accept) begin
          sh_d   = norm_d;
          h_d    = '0;
          bcnt_d = '0;
          st_d   = F_HASH;
        end
      end
      F_HASH: begin
        if (cur_byte == 8'd0) begin
          rem_d  = '0;
          mcnt_d = '0;
          st_d   = F_MOD;
        end else begin
          h_d    = (h_q << 5) - h_q + {24'd0, cur_byte};
          sh_d   = sh_q << 8;
          bcnt_d = bcnt_q + 3'd1;
          if (bcnt_q == 3'(KEY_BYTES - 1)) begin
            rem_d  = '0;
            mcnt_d = '0;
            st_d   = F_MOD;
          end
        end
      end
      F_MOD: begin
        if (trial >= {1'b0, size_i}) begin
          rem_d = SIZE_W'(trial - {1'b0, size_i});
        end else begin
          rem_d = trial[SIZE_W-1:0];
        end
        h_d    = h_q << 1;
        mcnt_d = mcnt_q + 5'd1;
        if (mcnt_q == 5'(HASH_W - 1)) begin
          st_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          st_d = F_IDLE;
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      norm_q <= norm_d;
    end
    sh_q   <= sh_d;
    h_q    <= h_d;
    rem_q  <= rem_d;
    bcnt_q <= bcnt_d;
    mcnt_q <= mcnt_d;
  end

endmodule

>>> sv/hslp_back.sv
// Back end: clears the slot states, probes the table and applies each request.
module hslp_back
  import hslp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SIZE_W-1:0] size_i,
  input  logic [SIZE_W-1:0] max_count_i,
  output logic              clearing_o,
  input  logic              q_empty_i,
  input  req_t              q_data_i,
  output logic              q_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic              outcome_o,
  output logic [SIZE_W-1:0] element_total_o,
  output logic [IDX_W-1:0]  slot_index_o
);

  localparam logic [2:0] B_CLEAR  = 3'd0;
  localparam logic [2:0] B_IDLE   = 3'd1;
  localparam logic [2:0] B_START  = 3'd2;
  localparam logic [2:0] B_PROBE  = 3'd3;
  localparam logic [2:0] B_FINISH = 3'd4;

  logic [1:0]        st_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]  key_mem [TABLE_DEPTH];

  logic [2:0]        st_q, st_d;
  req_t              req_q;
  logic [SIZE_W-1:0] clr_q, clr_d;
  logic [IDX_W-1:0]  locn_q, locn_d, next_locn, raddr;
  logic [SIZE_W-1:0] pcnt_q, pcnt_d;
  logic              htomb_q, htomb_d;
  logic [IDX_W-1:0]  tomb_q, tomb_d;
  logic              found_q, found_d, usable_q, usable_d;
  logic [IDX_W-1:0]  where_q, where_d;
  logic [1:0]        st_rd_q;
  logic [KEY_W-1:0]  key_rd_q;
  logic [SIZE_W-1:0] count_q, count_d;
  logic              ovalid_q, ovalid_d;
  logic              out_q, out_d;
  logic [IDX_W-1:0]  oslot_q, oslot_d;
  logic              st_we, key_we, finish;
  logic [IDX_W-1:0]  waddr;
  logic [1:0]        st_wdata;

  assign clearing_o      = (st_q == B_CLEAR);
  assign empty_o         = !ovalid_q;
  assign outcome_o       = out_q;
  assign element_total_o = count_q;
  assign slot_index_o    = oslot_q;
  assign q_pop_o         = (st_q == B_IDLE) && !q_empty_i;
  assign finish          = (st_q == B_FINISH) && (!ovalid_q || pop_i);
  assign next_locn       = ({1'b0, locn_q} + 1'b1 == size_i) ? '0 : locn_q + 1'b1;
  assign raddr           = (st_q == B_START) ? req_q.start : next_locn;

  always_comb begin
    st_d     = st_q;
    clr_d    = clr_q;
    locn_d   = locn_q;
    pcnt_d   = pcnt_q;
    htomb_d  = htomb_q;
    tomb_d   = tomb_q;
    found_d  = found_q;
    usable_d = usable_q;
    where_d  = where_q;
    count_d  = count_q;
    ovalid_d = ovalid_q && !pop_i;
    out_d    = out_q;
    oslot_d  = oslot_q;
    st_we    = 1'b0;
    key_we   = 1'b0;
    waddr    = where_q;
    st_wdata = SLOT_FILLED;
    unique case (st_q)
      B_CLEAR: begin
        st_we    = 1'b1;
        waddr    = clr_q[IDX_W-1:0];
        st_wdata = SLOT_EMPTY;
        clr_d    = clr_q + 1'b1;
        if (clr_q == SIZE_W'(TABLE_DEPTH - 1)) begin
          st_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty_i) begin
          st_d = B_START;
        end
      end
      B_START: begin
        locn_d  = req_q.start;
        pcnt_d  = '0;
        htomb_d = 1'b0;
        tomb_d  = '0;
        st_d    = B_PROBE;
      end
      B_PROBE: begin
        if (st_rd_q == SLOT_EMPTY) begin
          found_d  = 1'b0;
          where_d  = htomb_q ? tomb_q : locn_q;
          usable_d = 1'b1;
          st_d     = B_FINISH;
        end else if (st_rd_q == SLOT_FILLED && key_rd_q == req_q.key) begin
          found_d  = 1'b1;
          where_d  = locn_q;
          usable_d = 1'b1;
          st_d     = B_FINISH;
        end else begin
          if (st_rd_q != SLOT_FILLED && !htomb_q) begin
            htomb_d = 1'b1;
            tomb_d  = locn_q;
          end
          if (pcnt_q + 1'b1 == size_i) begin
            found_d  = 1'b0;
            where_d  = tomb_d;
            usable_d = htomb_d;
            st_d     = B_FINISH;
          end else begin
            pcnt_d = pcnt_q + 1'b1;
            locn_d = next_locn;
          end
        end
      end
      B_FINISH: begin
        if (finish) begin
          ovalid_d = 1'b1;
          out_d    = 1'b0;
          oslot_d  = '0;
          case (req_q.op)
            OP_LOOKUP: begin
              if (found_q) begin
                out_d   = 1'b1;
                oslot_d = where_q;
              end
            end
            OP_INSERT: begin
              if (found_q) begin
                oslot_d = where_q;
              end else if (count_q < max_count_i && usable_q) begin
                st_we    = 1'b1;
                key_we   = 1'b1;
                st_wdata = SLOT_FILLED;
                count_d  = count_q + 1'b1;
                out_d    = 1'b1;
                oslot_d  = where_q;
              end
            end
            OP_REMOVE: begin
              if (found_q) begin
                st_we    = 1'b1;
                st_wdata = SLOT_TOMB;
                if (count_q != '0) begin
                  count_d = count_q - 1'b1;
                end
                out_d   = 1'b1;
                oslot_d = where_q;
              end
            end
            default: ;
          endcase
          st_d = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= B_CLEAR;
      clr_q    <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      clr_q    <= clr_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      req_q <= q_data_i;
    end
    locn_q   <= locn_d;
    pcnt_q   <= pcnt_d;
    htomb_q  <= htomb_d;
    tomb_q   <= tomb_d;
    found_q  <= found_d;
    usable_q <= usable_d;
    where_q  <= where_d;
    out_q    <= out_d;
    oslot_q  <= oslot_d;
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[waddr] <= st_wdata;
    end
    st_rd_q <= st_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[waddr] <= req_q.key;
    end
    key_rd_q <= key_mem[raddr];
  end

endmodule

>>> sv/hash_set_linear_probe.sv
// Top level of the linear-probing hash set with its configuration registers.
// Each request is hashed one key byte per cycle (up to 8 bytes), its start
// slot is found by a one-bit-per-cycle remainder over the 32-bit hash, and
// the back end then probes one slot per cycle through the slot memories,
// with a start state before the probe and a finish state after it, which
// waits while an earlier result has not been popped. Front and back overlap
// through a two-entry queue, so the sustained rate is set by the slower of
// the two. After reset a clearing pass empties all 1024 slot states, and
// full stays high during it.
module hash_set_linear_probe
  import hslp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [KEY_W-1:0]  key_bytes_i,
  output logic              empty,
  input  logic              pop,
  output logic              outcome_o,
  output logic [SIZE_W-1:0] element_total_o,
  output logic [IDX_W-1:0]  slot_index_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [SIZE_W-1:0] table_size_q, max_count_q, eff_size;
  logic              cfg_we, clearing, busy;
  logic              q_push, q_full, q_pop, q_empty;
  req_t              q_wdata, q_rdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = paddr[2] ? {21'd0, max_count_q} : {21'd0, table_size_q};
  assign full   = busy;

  always_comb begin
    if (table_size_q == '0) begin
      eff_size = SIZE_W'(1);
    end else if (table_size_q > SIZE_W'(TABLE_DEPTH)) begin
      eff_size = SIZE_W'(TABLE_DEPTH);
    end else begin
      eff_size = table_size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= SIZE_W'(TABLE_DEPTH);
      max_count_q  <= SIZE_W'(TABLE_DEPTH);
    end else if (cfg_we) begin
      if (paddr[2]) begin
        max_count_q <= pwdata[SIZE_W-1:0];
      end else begin
        table_size_q <= pwdata[SIZE_W-1:0];
      end
    end
  end

  hslp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .operation_i (operation_i),
    .key_bytes_i (key_bytes_i),
    .hold_i      (clearing),
    .size_i      (eff_size),
    .busy_o      (busy),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata),
    .q_full_i    (q_full)
  );

  hslp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  hslp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .size_i          (eff_size),
    .max_count_i     (max_count_q),
    .clearing_o      (clearing),
    .q_empty_i       (q_empty),
    .q_data_i        (q_rdata),
    .q_pop_o         (q_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .outcome_o       (outcome_o),
    .element_total_o (element_total_o),
    .slot_index_o    (slot_index_o)
  );

endmodule

>>> sv/hslp_checker.sv
// Port-level checks for the hash set, bound to the top level.
module hslp_port_props
  import hslp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input logic              pready,
  input logic              outcome_o,
  input logic [SIZE_W-1:0] element_total_o,
  input logic [IDX_W-1:0]  slot_index_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(outcome_o) && $stable(slot_index_o)
                          && $stable(element_total_o)))
    else $error("Waiting result beat changed while stalled.");

  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (element_total_o <= SIZE_W'(TABLE_DEPTH)))
    else $error("Element total exceeds the table depth.");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("Configuration port was not ready.");

endmodule

bind hash_set_linear_probe hslp_port_props u_hslp_port_props (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .pready          (pready),
  .outcome_o       (outcome_o),
  .element_total_o (element_total_o),
  .slot_index_o    (slot_index_o)
);
